@@ src/bcpd_pkg.sv @@
package bcpd_pkg;

    // gesture machine states
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DOWN     = 3'd1,
        ST_UP       = 3'd2,
        ST_COUNT    = 3'd3,
        ST_PRESS    = 3'd4,
        ST_PRESSEND = 3'd5
    } t_gesture_state;

    // event codes on the output word
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_START  = 3'd1,
        EV_CLICK  = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_REPEAT = 3'd4,
        EV_STOP   = 3'd5
    } t_event;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ACTIVE_LOW   = 3'd0,
        CFG_DEBOUNCE_MS  = 3'd1,
        CFG_PRESS_MS     = 3'd2,
        CFG_CLICK_MS     = 3'd3,
        CFG_REPEAT_MS    = 3'd4,
        CFG_MAX_CLICKS   = 3'd5,
        CFG_EVENT_ENABLE = 3'd6
    } t_cfg_index;

    // bit positions in event_enable
    localparam int unsigned EN_START  = 0;
    localparam int unsigned EN_CLICK  = 1;
    localparam int unsigned EN_DOUBLE = 2;
    localparam int unsigned EN_REPEAT = 3;
    localparam int unsigned EN_STOP   = 4;

    // widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned ENABLE_W = 5;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 8;

    // reset values of the registers
    localparam logic                RST_ACTIVE_LOW   = 1'b1;
    localparam logic [MS_W-1:0]     RST_DEBOUNCE_MS  = 16'd50;
    localparam logic [MS_W-1:0]     RST_PRESS_MS     = 16'd800;
    localparam logic [MS_W-1:0]     RST_CLICK_MS     = 16'd400;
    localparam logic [MS_W-1:0]     RST_REPEAT_MS    = 16'd100;
    localparam logic [COUNT_W-1:0]  RST_MAX_CLICKS   = 4'd2;
    localparam logic [ENABLE_W-1:0] RST_EVENT_ENABLE = 5'd31;

    // click counts that give an event
    localparam logic [COUNT_W-1:0] ONE_CLICK = 4'd1;
    localparam logic [COUNT_W-1:0] TWO_CLICK = 4'd2;

endpackage

@@ src/button_click_press_detector_top.sv @@
// Button debounce and gesture detector. Each input word carries one raw pin
// sample and its 32-bit millisecond timestamp; each word gives exactly one
// output word with an event code (none, press start, click, double click,
// repeat, press stop) and the debounced level. A word is taken in every cycle:
// the debounce and gesture update is done in the cycle of acceptance and the
// result lands in a two-word output buffer, and the input stalls only when
// that buffer is full. Timing is driven purely by the timestamps in the
// stream, not by the clock. Write configuration only while no words are in
// flight; the configuration channel is always ready.
module button_click_press_detector_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // [0] raw_level, [32:1] time_ms, [39:33] zero
    input  logic [bcpd_pkg::IN_W-1:0] i_s_tdata,
    // output stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // [2:0] event_code, [3] clean_level, [7:4] zero
    output logic [bcpd_pkg::OUT_W-1:0] o_m_tdata,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [15:0]               i_cfg_data
);

    // configuration registers
    logic                             r_active_low;
    logic [bcpd_pkg::MS_W-1:0]        r_debounce_ms;
    logic [bcpd_pkg::MS_W-1:0]        r_press_ms;
    logic [bcpd_pkg::MS_W-1:0]        r_click_ms;
    logic [bcpd_pkg::MS_W-1:0]        r_repeat_ms;
    logic [bcpd_pkg::COUNT_W-1:0]     r_max_clicks;
    logic [bcpd_pkg::ENABLE_W-1:0]    r_event_enable;

    // detector state
    bcpd_pkg::t_gesture_state         r_state, n_state;
    logic [bcpd_pkg::COUNT_W-1:0]     r_click_count, n_click_count;
    logic [bcpd_pkg::TIME_W-1:0]      r_phase_start, n_phase_start;
    logic [bcpd_pkg::TIME_W-1:0]      r_last_change, n_last_change;
    logic [bcpd_pkg::TIME_W-1:0]      r_last_repeat, n_last_repeat;
    logic                             r_last_raw, n_last_raw;
    logic                             r_debounced, n_debounced;
    bcpd_pkg::t_event                 n_event;

    // output buffer
    logic [3:0] r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic                         s_accept;
    logic                         m_accept;
    logic                         in_raw;
    logic [bcpd_pkg::TIME_W-1:0]  in_time;
    logic [bcpd_pkg::TIME_W-1:0]  since_change;
    logic [bcpd_pkg::TIME_W-1:0]  wait_time;
    logic [bcpd_pkg::TIME_W-1:0]  since_repeat;
    logic                         active;
    logic                         cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;
    assign o_s_tready  = (r_count != 2'd2);
    assign s_accept    = i_s_tvalid & o_s_tready;
    assign o_m_tvalid  = (r_count != 2'd0);
    assign m_accept    = o_m_tvalid & i_m_tready;
    assign o_m_tdata   = {4'd0, r_buf[r_rd_ptr]};

    assign in_raw  = i_s_tdata[0];
    assign in_time = i_s_tdata[32:1];

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low   <= bcpd_pkg::RST_ACTIVE_LOW;
            r_debounce_ms  <= bcpd_pkg::RST_DEBOUNCE_MS;
            r_press_ms     <= bcpd_pkg::RST_PRESS_MS;
            r_click_ms     <= bcpd_pkg::RST_CLICK_MS;
            r_repeat_ms    <= bcpd_pkg::RST_REPEAT_MS;
            r_max_clicks   <= bcpd_pkg::RST_MAX_CLICKS;
            r_event_enable <= bcpd_pkg::RST_EVENT_ENABLE;
        end else if (cfg_write) begin
            unique case (bcpd_pkg::t_cfg_index'(i_cfg_index))
                bcpd_pkg::CFG_ACTIVE_LOW:   r_active_low   <= i_cfg_data[0];
                bcpd_pkg::CFG_DEBOUNCE_MS:  r_debounce_ms  <= i_cfg_data;
                bcpd_pkg::CFG_PRESS_MS:     r_press_ms     <= i_cfg_data;
                bcpd_pkg::CFG_CLICK_MS:     r_click_ms     <= i_cfg_data;
                bcpd_pkg::CFG_REPEAT_MS:    r_repeat_ms    <= i_cfg_data;
                bcpd_pkg::CFG_MAX_CLICKS:
                    r_max_clicks <= i_cfg_data[bcpd_pkg::COUNT_W-1:0];
                bcpd_pkg::CFG_EVENT_ENABLE:
                    r_event_enable <= i_cfg_data[bcpd_pkg::ENABLE_W-1:0];
                default: ;
            endcase
        end
    end

    // debounce: follow the raw level once it has held long enough
    always_comb begin
        since_change  = in_time - r_last_change;
        n_last_change = r_last_change;
        n_last_raw    = r_last_raw;
        n_debounced   = r_debounced;
        if (r_last_raw == in_raw) begin
            if (since_change >= {16'd0, r_debounce_ms}) begin
                n_debounced = in_raw;
            end
        end else begin
            n_last_change = in_time;
            n_last_raw    = in_raw;
        end
        active       = (n_debounced == ~r_active_low);
        wait_time    = in_time - r_phase_start;
        since_repeat = in_time - r_last_repeat;
    end

    // gesture machine: next state and event
    always_comb begin
        n_state       = r_state;
        n_click_count = r_click_count;
        n_phase_start = r_phase_start;
        n_last_repeat = r_last_repeat;
        n_event       = bcpd_pkg::EV_NONE;
        unique case (r_state)
            bcpd_pkg::ST_IDLE: begin
                if (active) begin
                    n_state       = bcpd_pkg::ST_DOWN;
                    n_phase_start = in_time;
                    n_click_count = '0;
                end
            end
            bcpd_pkg::ST_DOWN: begin
                if (!active) begin
                    n_state       = bcpd_pkg::ST_UP;
                    n_phase_start = in_time;
                end else if (wait_time > {16'd0, r_press_ms}) begin
                    if (r_event_enable[bcpd_pkg::EN_START]) begin
                        n_event = bcpd_pkg::EV_START;
                    end
                    n_state = bcpd_pkg::ST_PRESS;
                end
            end
            bcpd_pkg::ST_UP: begin
                n_click_count = r_click_count + 4'd1;
                n_state       = bcpd_pkg::ST_COUNT;
            end
            bcpd_pkg::ST_COUNT: begin
                if (active) begin
                    n_state       = bcpd_pkg::ST_DOWN;
                    n_phase_start = in_time;
                end else if (wait_time >= {16'd0, r_click_ms} ||
                             r_click_count == r_max_clicks) begin
                    if (r_click_count == bcpd_pkg::ONE_CLICK) begin
                        if (r_event_enable[bcpd_pkg::EN_CLICK]) begin
                            n_event = bcpd_pkg::EV_CLICK;
                        end
                    end else if (r_click_count == bcpd_pkg::TWO_CLICK) begin
                        if (r_event_enable[bcpd_pkg::EN_DOUBLE]) begin
                            n_event = bcpd_pkg::EV_DOUBLE;
                        end
                    end
                    n_state       = bcpd_pkg::ST_IDLE;
                    n_click_count = '0;
                    n_phase_start = in_time;
                end
            end
            bcpd_pkg::ST_PRESS: begin
                if (!active) begin
                    n_state = bcpd_pkg::ST_PRESSEND;
                end else if (since_repeat >= {16'd0, r_repeat_ms}) begin
                    if (r_event_enable[bcpd_pkg::EN_REPEAT]) begin
                        n_event = bcpd_pkg::EV_REPEAT;
                    end
                    n_last_repeat = in_time;
                end
            end
            bcpd_pkg::ST_PRESSEND: begin
                if (r_event_enable[bcpd_pkg::EN_STOP]) begin
                    n_event = bcpd_pkg::EV_STOP;
                end
                n_state       = bcpd_pkg::ST_IDLE;
                n_click_count = '0;
                n_phase_start = in_time;
            end
            default: begin
                n_state = bcpd_pkg::ST_IDLE;
            end
        endcase
    end

    // state registers, updated on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bcpd_pkg::ST_IDLE;
            r_click_count <= '0;
            r_phase_start <= '0;
            r_last_change <= '0;
            r_last_repeat <= '0;
            r_last_raw    <= bcpd_pkg::RST_ACTIVE_LOW;
            r_debounced   <= bcpd_pkg::RST_ACTIVE_LOW;
        end else if (s_accept) begin
            r_state       <= n_state;
            r_click_count <= n_click_count;
            r_phase_start <= n_phase_start;
            r_last_change <= n_last_change;
            r_last_repeat <= n_last_repeat;
            r_last_raw    <= n_last_raw;
            r_debounced   <= n_debounced;
        end
    end

    // two-word output buffer
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_buf[r_wr_ptr] <= {n_debounced, n_event};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (s_accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (m_accept) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (s_accept && !m_accept) begin
                r_count <= r_count + 2'd1;
            end else if (!s_accept && m_accept) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // buffer never holds more than two words
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("output buffer overfilled");

    // a release is always counted on the following word
    a_up_to_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_state == bcpd_pkg::ST_UP) |=> r_state == bcpd_pkg::ST_COUNT)
        else $error("up state did not move to count");

    // press stop only leaves the press end state
    a_stop_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_state != bcpd_pkg::ST_PRESSEND) |-> n_event != bcpd_pkg::EV_STOP)
        else $error("press stop outside press end");

    // repeat only while a long press is held
    a_repeat_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && n_event == bcpd_pkg::EV_REPEAT) |-> r_state == bcpd_pkg::ST_PRESS)
        else $error("repeat outside long press");

    // reset leaves the machine idle with an empty buffer
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == bcpd_pkg::ST_IDLE && r_count == 2'd0))
        else $error("reset did not clear state");

endmodule
